// File: hdl/ssst_pkg.sv
// Package for the sortable search table: sizes, operation codes, engine states
// and the request and result records passed between the engine and the top level.
// Depends on nothing.
package ssst_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int LEN_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 10;
  localparam int OP_W  = 3;
  localparam int CNT_W = 12;
  localparam int CFG_W = 7;

  localparam logic [CFG_W-1:0] LENGTH_RESET = CFG_W'(64);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 3'd0,
    OP_SORT    = 3'd1,
    OP_BSEARCH = 3'd2,
    OP_LSEARCH = 3'd3,
    OP_READ    = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT_RDS,
    ST_SORT_WS,
    ST_SORT_RDI,
    ST_SORT_CMP,
    ST_SORT_WR1,
    ST_SORT_WR2,
    ST_BS_RD,
    ST_BS_CMP,
    ST_LS_RD,
    ST_LS_CMP,
    ST_RD_ISSUE,
    ST_RD_CAP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
    logic [CNT_W-1:0] op_count;
    logic [VAL_W-1:0] read_value;
  } res_t;

endpackage

// File: hdl/ssst_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module ssst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/ssst_engine.sv
// Sequencer for the sortable search table: runs load, sort, searches and read
// against the table RAM, one access per cycle. Depends on ssst_pkg.
module ssst_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  ssst_pkg::req_t              req,
  input  logic [ssst_pkg::LEN_W-1:0]  n_used,
  output logic                        res_valid,
  input  logic                        res_ready,
  output ssst_pkg::res_t              res,
  output logic                        mem_we,
  output logic [ssst_pkg::IDX_W-1:0]  mem_waddr,
  output logic [ssst_pkg::VAL_W-1:0]  mem_wdata,
  output logic                        mem_re,
  output logic [ssst_pkg::IDX_W-1:0]  mem_raddr,
  input  logic [ssst_pkg::VAL_W-1:0]  mem_rdata
);
  import ssst_pkg::*;

  state_t           state_r, state_nxt;
  logic [VAL_W-1:0] key_r, key_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [LEN_W-1:0] n_r, n_nxt;
  logic [LEN_W-1:0] s_r, s_nxt;
  logic [LEN_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] m_r, m_nxt;
  logic [VAL_W-1:0] minv_r, minv_nxt;
  logic [VAL_W-1:0] sv_r, sv_nxt;
  logic [LEN_W-1:0] lo_r, lo_nxt;
  logic [LEN_W-1:0] hi1_r, hi1_nxt;
  logic [IDX_W-1:0] mid_r, mid_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [VAL_W-1:0] rv_r, rv_nxt;

  logic             new_min;
  logic [CNT_W:0]   cnt_sum;
  logic [CNT_W-1:0] cnt_sat;
  logic [LEN_W:0]   mid_sum;
  logic [IDX_W-1:0] mid_w;

  // A new minimum costs one extra count on top of the comparison.
  assign new_min = (mem_rdata < minv_r);
  assign cnt_sum = {1'b0, cnt_r} + (((state_r == ST_SORT_CMP) && new_min) ?
                   (CNT_W+1)'(2) : (CNT_W+1)'(1));
  assign cnt_sat = cnt_sum[CNT_W] ? {CNT_W{1'b1}} : cnt_sum[CNT_W-1:0];

  // hi1 holds hi + 1, so the probe is floor((lo + hi1 - 1) / 2) while lo < hi1.
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi1_r} - (LEN_W+1)'(1);
  assign mid_w   = mid_sum[IDX_W:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    idx_r   <= idx_nxt;
    n_r     <= n_nxt;
    s_r     <= s_nxt;
    i_r     <= i_nxt;
    m_r     <= m_nxt;
    minv_r  <= minv_nxt;
    sv_r    <= sv_nxt;
    lo_r    <= lo_nxt;
    hi1_r   <= hi1_nxt;
    mid_r   <= mid_nxt;
    found_r <= found_nxt;
    pos_r   <= pos_nxt;
    cnt_r   <= cnt_nxt;
    rv_r    <= rv_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    idx_nxt   = idx_r;
    n_nxt     = n_r;
    s_nxt     = s_r;
    i_nxt     = i_r;
    m_nxt     = m_r;
    minv_nxt  = minv_r;
    sv_nxt    = sv_r;
    lo_nxt    = lo_r;
    hi1_nxt   = hi1_r;
    mid_nxt   = mid_r;
    found_nxt = found_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    rv_nxt    = rv_r;
    req_ready = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;

    unique case (state_r)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          key_nxt   = req.value;
          idx_nxt   = req.index;
          n_nxt     = n_used;
          s_nxt     = '0;
          i_nxt     = '0;
          lo_nxt    = '0;
          hi1_nxt   = n_used;
          found_nxt = 1'b0;
          pos_nxt   = '0;
          cnt_nxt   = '0;
          rv_nxt    = '0;
          unique case (req.operation)
            OP_LOAD: begin
              mem_we    = 1'b1;
              mem_waddr = req.index;
              mem_wdata = req.value;
              state_nxt = ST_DONE;
            end
            OP_SORT:    state_nxt = (n_used >= LEN_W'(2)) ? ST_SORT_RDS : ST_DONE;
            OP_BSEARCH: state_nxt = ST_BS_RD;
            OP_LSEARCH: state_nxt = ST_LS_RD;
            OP_READ:    state_nxt = ST_RD_ISSUE;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SORT_RDS: begin
        mem_re    = 1'b1;
        mem_raddr = s_r[IDX_W-1:0];
        state_nxt = ST_SORT_WS;
      end
      ST_SORT_WS: begin
        sv_nxt    = mem_rdata;
        minv_nxt  = mem_rdata;
        m_nxt     = s_r[IDX_W-1:0];
        i_nxt     = s_r + LEN_W'(1);
        state_nxt = ST_SORT_RDI;
      end
      ST_SORT_RDI: begin
        mem_re    = 1'b1;
        mem_raddr = i_r[IDX_W-1:0];
        state_nxt = ST_SORT_CMP;
      end
      ST_SORT_CMP: begin
        cnt_nxt = cnt_sat;
        if (new_min) begin
          m_nxt    = i_r[IDX_W-1:0];
          minv_nxt = mem_rdata;
        end
        if ((i_r + LEN_W'(1)) < n_r) begin
          i_nxt     = i_r + LEN_W'(1);
          state_nxt = ST_SORT_RDI;
        end else begin
          state_nxt = ST_SORT_WR1;
        end
      end
      ST_SORT_WR1: begin
        mem_we    = 1'b1;
        mem_waddr = s_r[IDX_W-1:0];
        mem_wdata = minv_r;
        state_nxt = ST_SORT_WR2;
      end
      ST_SORT_WR2: begin
        // When the minimum was already in place this rewrites the same value.
        mem_we    = 1'b1;
        mem_waddr = m_r;
        mem_wdata = sv_r;
        s_nxt     = s_r + LEN_W'(1);
        state_nxt = ((s_r + LEN_W'(2)) < n_r) ? ST_SORT_RDS : ST_DONE;
      end
      ST_BS_RD: begin
        if (lo_r < hi1_r) begin
          mem_re    = 1'b1;
          mem_raddr = mid_w;
          mid_nxt   = mid_w;
          state_nxt = ST_BS_CMP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_BS_CMP: begin
        cnt_nxt = cnt_sat;
        if (mem_rdata == key_r) begin
          found_nxt = 1'b1;
          pos_nxt   = mid_r;
          state_nxt = ST_DONE;
        end else if (mem_rdata < key_r) begin
          lo_nxt    = LEN_W'(mid_r) + LEN_W'(1);
          state_nxt = ST_BS_RD;
        end else begin
          hi1_nxt   = LEN_W'(mid_r);
          state_nxt = ST_BS_RD;
        end
      end
      ST_LS_RD: begin
        if (i_r < n_r) begin
          mem_re    = 1'b1;
          mem_raddr = i_r[IDX_W-1:0];
          state_nxt = ST_LS_CMP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_LS_CMP: begin
        cnt_nxt = cnt_sat;
        if (mem_rdata == key_r) begin
          found_nxt = 1'b1;
          pos_nxt   = i_r[IDX_W-1:0];
          state_nxt = ST_DONE;
        end else if (key_r < mem_rdata) begin
          state_nxt = ST_DONE;
        end else begin
          i_nxt     = i_r + LEN_W'(1);
          state_nxt = ST_LS_RD;
        end
      end
      ST_RD_ISSUE: begin
        mem_re    = 1'b1;
        mem_raddr = idx_r;
        state_nxt = ST_RD_CAP;
      end
      ST_RD_CAP: begin
        rv_nxt    = mem_rdata;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign res = '{found: found_r, position: pos_r, op_count: cnt_r, read_value: rv_r};

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("table read and write issued in the same cycle");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(req_ready && res_valid))
    else $error("new item taken while a result is pending");

  a_found_probed: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.found) |-> (res.op_count != '0))
    else $error("key reported found without any probe");

  a_swap_second: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SORT_WR1) |=> (mem_we && (mem_waddr == $past(m_r))))
    else $error("swap did not write the old entry to the minimum slot");

  a_bs_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BS_RD) |-> (lo_r <= hi1_r))
    else $error("binary search bounds crossed");

endmodule

// File: hdl/selection_sort_search_table.sv
// Sortable search table: a 64-entry table of 10-bit values with load, selection sort,
// binary search, ordered linear search and read, one result per item. An item waits in
// the sequencer while the previous result sits in the output register. Every table read
// goes through the one registered RAM read port. A search reads one entry per probe; each
// pass of a sort reads its first entry, reads and compares each remaining entry in turn,
// then writes the swap with two writes; a sort over fewer than two entries goes straight
// to its result. Depends on ssst_pkg, ssst_ram and ssst_engine.
module selection_sort_search_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ssst_pkg::OP_W-1:0]  in_operation,
  input  logic [ssst_pkg::VAL_W-1:0] in_value,
  input  logic [ssst_pkg::IDX_W-1:0] in_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_found,
  output logic [ssst_pkg::IDX_W-1:0] out_position,
  output logic [ssst_pkg::CNT_W-1:0] out_op_count,
  output logic [ssst_pkg::VAL_W-1:0] out_read_value,
  input  logic                       cfg_wr_en,
  input  logic [ssst_pkg::CFG_W-1:0] cfg_wr_data
);
  import ssst_pkg::*;

  logic [CFG_W-1:0] length_r;
  logic [LEN_W-1:0] n_used;
  req_t             req;
  res_t             res;
  logic             res_valid;
  logic             res_ready;
  logic             out_valid_r;
  res_t             out_res_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [VAL_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r <= LENGTH_RESET;
    end else if (cfg_wr_en) begin
      length_r <= cfg_wr_data;
    end
  end

  // Lengths past the table size use the whole table.
  assign n_used = (length_r > CFG_W'(DEPTH)) ? LEN_W'(DEPTH) : LEN_W'(length_r);

  assign req = '{operation: in_operation, value: in_value, index: in_index};

  ssst_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .req       (req),
    .n_used    (n_used),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ssst_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_res_r.found;
  assign out_position   = out_res_r.position;
  assign out_op_count   = out_res_r.op_count;
  assign out_read_value = out_res_r.read_value;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for selection_sort_search_table: directed and random table operations,
// each result checked against a cycle-free predictor of the table and its length register.
// Depends on ssst_pkg and the RTL of the block.
module tb_top;
  import ssst_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int PHASE_ITEMS  = 95;
  localparam int NUM_PHASES   = 16;
  localparam int LONG_HOLD    = 400;
  localparam int SETTLE       = 20;
  localparam int MAX_REPORTS  = 10;
  localparam logic [OP_W-1:0]  OP_LAST = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [VAL_W-1:0] VAL_MAX = '1;
  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
    bit               drain;
  } table_op_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [OP_W-1:0]  in_operation;
  logic [VAL_W-1:0] in_value;
  logic [IDX_W-1:0] in_index;
  logic             out_valid;
  logic             out_ready;
  logic             out_found;
  logic [IDX_W-1:0] out_position;
  logic [CNT_W-1:0] out_op_count;
  logic [VAL_W-1:0] out_read_value;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  // Predicted state of the block.
  logic [VAL_W-1:0] model_tbl [DEPTH];
  logic [CFG_W-1:0] model_len;
  res_t             table_results [$];

  // Stimulus side: items waiting for the driver and what has been loaded so far.
  table_op_t        op_queue [$];
  logic [VAL_W-1:0] gen_vals [DEPTH];
  bit               gen_written [DEPTH];
  int               gen_count;

  logic in_hs;
  bit   quiet;
  int   send_wait;
  int   stall_left;
  int   hold_left;
  int   hold_req;
  int   hold_ack;
  int   mismatches;
  int   cycle_cnt;

  selection_sort_search_table u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .in_index       (in_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_position   (out_position),
    .out_op_count   (out_op_count),
    .out_read_value (out_read_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Applies one item to the predicted table and returns the result it should produce.
  function automatic res_t table_step(input logic [OP_W-1:0] op,
                                      input logic [VAL_W-1:0] key,
                                      input logic [IDX_W-1:0] idx);
    res_t             r;
    int               n, s, i, m, lo, hi, mid, pos;
    int unsigned      cnt;
    logic [VAL_W-1:0] t;
    bit               done;
    r    = '0;
    cnt  = 0;
    pos  = -1;
    done = 1'b0;
    n    = (model_len > DEPTH) ? DEPTH : int'(model_len);
    case (op)
      OP_LOAD: model_tbl[idx] = key;
      OP_SORT: begin
        for (s = 0; s + 1 < n; s++) begin
          m = s;
          for (i = s + 1; i < n; i++) begin
            cnt++;
            if (model_tbl[i] < model_tbl[m]) begin
              m = i;
              cnt++;
            end
          end
          t            = model_tbl[s];
          model_tbl[s] = model_tbl[m];
          model_tbl[m] = t;
        end
      end
      OP_BSEARCH: begin
        lo = 0;
        hi = n - 1;
        while (lo <= hi && !done) begin
          mid = (lo + hi) / 2;
          cnt++;
          if (model_tbl[mid] == key) begin
            pos  = mid;
            done = 1'b1;
          end else if (model_tbl[mid] < key) begin
            lo = mid + 1;
          end else begin
            hi = mid - 1;
          end
        end
      end
      OP_LSEARCH: begin
        // The table is taken as ascending, so a larger entry ends the scan.
        for (i = 0; i < n && !done; i++) begin
          cnt++;
          if (model_tbl[i] == key) begin
            pos  = i;
            done = 1'b1;
          end else if (key < model_tbl[i]) begin
            done = 1'b1;
          end
        end
      end
      OP_READ: r.read_value = model_tbl[idx];
      default: ;
    endcase
    if (op == OP_SORT || op == OP_BSEARCH || op == OP_LSEARCH)
      r.op_count = (cnt > CNT_MAX) ? CNT_MAX : CNT_W'(cnt);
    if (pos >= 0) begin
      r.found    = 1'b1;
      r.position = IDX_W'(pos);
    end
    return r;
  endfunction

  // Driver: presents the next pending item once the current one is taken and its gap is over.
  always @(negedge clk) begin
    table_op_t nxt;
    if (!in_valid || in_hs) begin
      if (send_wait > 0) begin
        in_valid  <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (op_queue.size() > 0 &&
                   !(op_queue[0].drain && table_results.size() > 0)) begin
        nxt          = op_queue.pop_front();
        in_operation <= nxt.op;
        in_value     <= nxt.value;
        in_index     <= nxt.index;
        in_valid     <= 1'b1;
        send_wait    <= idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side ready, with random stalls and the occasional long hold-off.
  always @(negedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack  <= hold_req;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= idle_len();
    end
  end

  // Monitor: checks each delivered result, then predicts for an item taken at this edge.
  always @(posedge clk) begin
    res_t want;
    res_t got;
    in_hs <= rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      got = {out_found, out_position, out_op_count, out_read_value};
      if (table_results.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected result: found=%0d pos=%0d count=%0d value=%0d",
                   got.found, got.position, got.op_count, got.read_value);
        mismatches <= mismatches + 1;
      end else begin
        want = table_results.pop_front();
        if (got.found !== want.found || got.position !== want.position ||
            got.op_count !== want.op_count || got.read_value !== want.read_value) begin
          if (mismatches < MAX_REPORTS)
            $display({"mismatch: expected found=%0d pos=%0d count=%0d value=%0d, ",
                      "got %0d %0d %0d %0d"},
                     want.found, want.position, want.op_count, want.read_value,
                     got.found, got.position, got.op_count, got.read_value);
          mismatches <= mismatches + 1;
        end
      end
    end
    if (rst_n && in_valid && in_ready)
      table_results.push_back(table_step(in_operation, in_value, in_index));
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [CFG_W-1:0] phase_len(input int p);
    case (p)
      0:       return CFG_W'(127);
      1:       return CFG_W'(1);
      2:       return CFG_W'(2);
      3:       return CFG_W'(5);
      4:       return CFG_W'(8);
      5:       return CFG_W'(16);
      6:       return CFG_W'(3);
      7:       return CFG_W'(64);
      8:       return CFG_W'(33);
      9:       return CFG_W'(0);
      10:      return CFG_W'(12);
      11:      return CFG_W'(100);
      12:      return CFG_W'(7);
      13:      return CFG_W'(24);
      14:      return CFG_W'(64);
      default: return CFG_W'(4);
    endcase
  endfunction

  task automatic queue_op(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] v,
                          input logic [IDX_W-1:0] idx, input bit drain);
    table_op_t t;
    if (op == OP_LOAD) begin
      gen_vals[idx]    = v;
      gen_written[idx] = 1'b1;
    end
    t.op    = op;
    t.value = v;
    t.index = idx;
    t.drain = drain;
    op_queue.push_back(t);
    gen_count++;
  endtask

  // Keys are mostly taken from the used part of the table so that searches hit.
  function automatic logic [VAL_W-1:0] search_key(input int used);
    int r;
    r = $urandom_range(0, 9);
    if (used > 0 && r < 6) return gen_vals[$urandom_range(0, used - 1)];
    if (r < 7) return '0;
    if (r < 8) return VAL_MAX;
    return VAL_W'($urandom);
  endfunction

  task automatic add_random_item(input int used);
    int               r, k, tries;
    logic [VAL_W-1:0] v;
    bit               drain;
    r     = $urandom_range(0, 99);
    drain = ($urandom_range(0, 49) == 0);
    if (r < 30) begin
      k = $urandom_range(0, 9);
      v = (k == 0) ? '0 : (k == 1) ? VAL_MAX : VAL_W'($urandom);
      if (used > 0 && $urandom_range(0, 3) != 0) k = $urandom_range(0, used - 1);
      else k = $urandom_range(0, DEPTH - 1);
      queue_op(OP_LOAD, v, IDX_W'(k), drain);
    end else if (r < 30 + ((used <= 16) ? 8 : 3)) begin
      // A sort is followed by lookups on the freshly ordered table.
      queue_op(OP_SORT, VAL_W'($urandom), IDX_W'($urandom), drain);
      repeat ($urandom_range(1, 3))
        queue_op(OP_BSEARCH, search_key(used), IDX_W'($urandom), 1'b0);
    end else if (r < 55) begin
      queue_op(OP_BSEARCH, search_key(used), IDX_W'($urandom), drain);
    end else if (r < 78) begin
      queue_op(OP_LSEARCH, search_key(used), IDX_W'($urandom), drain);
    end else if (r < 95) begin
      k     = $urandom_range(0, DEPTH - 1);
      tries = 0;
      while (!gen_written[k] && tries < 8) begin
        k = $urandom_range(0, DEPTH - 1);
        tries++;
      end
      if (!gen_written[k]) k = IDX_MAX;
      queue_op(OP_READ, VAL_W'($urandom), IDX_W'(k), drain);
    end else begin
      queue_op(OP_W'($urandom_range(OP_READ + 1, OP_LAST)), VAL_W'($urandom),
               IDX_W'($urandom), drain);
    end
  endtask

  task automatic wait_idle();
    while (op_queue.size() != 0 || in_valid || table_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_length(input logic [CFG_W-1:0] len);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    model_len = len;
    @(posedge clk);
  endtask

  initial begin
    int p, i, used, start;
    logic [CFG_W-1:0] len;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = OP_LOAD;
    in_value     = '0;
    in_index     = '0;
    out_ready    = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_hs        = 1'b0;
    quiet        = 1'b0;
    send_wait    = 0;
    stall_left   = 0;
    hold_left    = 0;
    hold_req     = 0;
    hold_ack     = 0;
    mismatches   = 0;
    cycle_cnt    = 0;
    gen_count    = 0;
    model_len    = LENGTH_RESET;
    for (i = 0; i < DEPTH; i++) begin
      model_tbl[i]   = '0;
      gen_vals[i]    = '0;
      gen_written[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extreme values at the extreme indexes, read back, then the unused operation codes.
    queue_op(OP_LOAD, '0, '0, 1'b0);
    queue_op(OP_LOAD, VAL_MAX, IDX_MAX, 1'b0);
    queue_op(OP_READ, '0, IDX_MAX, 1'b0);
    queue_op(OP_READ, VAL_MAX, '0, 1'b0);
    for (i = OP_READ + 1; i <= OP_LAST; i++)
      queue_op(OP_W'(i), VAL_W'($urandom), IDX_W'($urandom), 1'b0);

    // With no entries in use, sort and searches touch nothing.
    write_length('0);
    queue_op(OP_SORT, '0, '0, 1'b0);
    queue_op(OP_BSEARCH, '0, '0, 1'b0);
    queue_op(OP_LSEARCH, VAL_MAX, '0, 1'b0);

    // Four entries: a search before sorting, the sort, then hits, misses and an early stop.
    write_length(CFG_W'(4));
    queue_op(OP_LOAD, VAL_W'(700), IDX_W'(0), 1'b0);
    queue_op(OP_LOAD, VAL_MAX, IDX_W'(1), 1'b0);
    queue_op(OP_LOAD, '0, IDX_W'(2), 1'b0);
    queue_op(OP_LOAD, VAL_W'(512), IDX_W'(3), 1'b0);
    queue_op(OP_BSEARCH, VAL_W'(512), '0, 1'b0);
    queue_op(OP_SORT, '0, '0, 1'b0);
    queue_op(OP_BSEARCH, VAL_W'(512), '0, 1'b0);
    queue_op(OP_BSEARCH, VAL_MAX, '0, 1'b0);
    queue_op(OP_BSEARCH, VAL_W'(100), '0, 1'b0);
    queue_op(OP_LSEARCH, VAL_W'(600), '0, 1'b0);
    queue_op(OP_LSEARCH, VAL_MAX, '0, 1'b1);
    queue_op(OP_READ, '0, IDX_W'(2), 1'b0);

    for (p = 0; p < NUM_PHASES; p++) begin
      len  = phase_len(p);
      used = (len > DEPTH) ? DEPTH : int'(len);
      write_length(len);
      quiet = (p == 4 || p == 11);
      if (p == 2 || p == 9) hold_req = hold_req + 1;
      start = gen_count;
      // Every entry that sort or a search may touch gets loaded first.
      for (i = 0; i < used; i++)
        if (!gen_written[i]) queue_op(OP_LOAD, VAL_W'($urandom), IDX_W'(i), 1'b0);
      while (gen_count - start < PHASE_ITEMS) add_random_item(used);
    end

    wait_idle();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
